>>> hw/rtl/rpc_port_mapping_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the port mapping table core.
// Each macro states one clocked property, reset disables it.
// ----------------------------------------------------------------------------
`ifndef RPC_PORT_MAPPING_TABLE_CORE_ASSERT_SVH
`define RPC_PORT_MAPPING_TABLE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define RPMT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("port mapping table assertion failed");

// Antecedent implies consequent in the next cycle.
`define RPMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("port mapping table assertion failed");

`else

`define RPMT_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define RPMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/rpmt_pkg.sv
// ----------------------------------------------------------------------------
// Port mapping table package
// Shared codes, widths and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rpmt_pkg;

    // Default table depth.
    localparam int DEF_TABLE_ENTRIES = 16;

    // Field widths.
    localparam int WORD_W   = 32;
    localparam int PORT_W   = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OWN_PROGRAM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_VERSION = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [WORD_W-1:0] OWN_PROGRAM_RST = 32'd100000;
    localparam logic [WORD_W-1:0] OWN_VERSION_RST = 32'd2;

    // Procedure numbers.
    localparam logic [WORD_W-1:0] PROC_NULL    = 32'd0;
    localparam logic [WORD_W-1:0] PROC_SET     = 32'd1;
    localparam logic [WORD_W-1:0] PROC_UNSET   = 32'd2;
    localparam logic [WORD_W-1:0] PROC_GETPORT = 32'd3;
    localparam logic [WORD_W-1:0] PROC_DUMP    = 32'd4;
    localparam logic [WORD_W-1:0] PROC_CALLIT  = 32'd5;

    // Reply status codes.
    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PROG_UNAVAIL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PROG_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PROC_UNAVAIL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_GARBAGE_ARGS  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SET_REFUSED   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan_clear;
        logic scan_issue;
        logic res_load;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpmt_datapath.sv
// ----------------------------------------------------------------------------
// Port mapping table datapath
// Holds the request, the configuration, the table memory with its
// occupancy bits, the scan accumulators and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmt_datapath #(
    parameter int TABLE_ENTRIES = rpmt_pkg::DEF_TABLE_ENTRIES
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [rpmt_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wire  [rpmt_pkg::WORD_W-1:0]          cfg_wr_data,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_func,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_header_program,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_header_version,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_map_program,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_map_version,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_map_protocol,
    input  wire  [rpmt_pkg::PORT_W-1:0]          s_map_port,
    input  wire                                  s_trailing_data,
    input  rpmt_pkg::ctrl_cmd_t                  cmd,
    output rpmt_pkg::dp_status_t                 sts,
    output logic [rpmt_pkg::STATUS_W-1:0]        m_status,
    output logic [rpmt_pkg::PORT_W-1:0]          m_found_port,
    output logic [rpmt_pkg::WORD_W-1:0]          m_supported_version
);

    import rpmt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic [WORD_W-1:0] prog;
        logic [WORD_W-1:0] version;
        logic [WORD_W-1:0] protocol;
        logic [PORT_W-1:0] port;
    } entry_t;

    // Configuration registers.
    logic [WORD_W-1:0] own_program_reg;
    logic [WORD_W-1:0] own_version_reg;

    // Captured request.
    logic [WORD_W-1:0] req_func_reg;
    logic [WORD_W-1:0] req_hprog_reg;
    logic [WORD_W-1:0] req_hver_reg;
    logic [WORD_W-1:0] req_mprog_reg;
    logic [WORD_W-1:0] req_mver_reg;
    logic [WORD_W-1:0] req_mprot_reg;
    logic [PORT_W-1:0] req_mport_reg;
    logic              req_trail_reg;

    // Table storage and occupancy.
    entry_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    entry_t                   rd_data_reg;
    logic                     occ_reg;

    // Scan control and accumulators.
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_en_reg;
    logic              dup_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              hit_reg;
    logic [PORT_W-1:0] hit_port_reg;

    // Result registers.
    logic [STATUS_W-1:0] res_status_reg;
    logic [PORT_W-1:0]   res_port_reg;
    logic [WORD_W-1:0]   res_supp_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [PORT_W-1:0]   out_port_reg;
    logic [WORD_W-1:0]   out_supp_reg;

    logic [STATUS_W-1:0] early_status;
    logic [WORD_W-1:0]   early_supp;
    logic                need_scan;
    logic                is_set;
    logic [PORT_W-1:0]   ent_port;
    logic                ent_match;
    logic [STATUS_W-1:0] scan_status;
    logic [PORT_W-1:0]   scan_port;
    logic                mem_we;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_program_reg <= OWN_PROGRAM_RST;
            own_version_reg <= OWN_VERSION_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_OWN_PROGRAM: own_program_reg <= cfg_wr_data;
                REG_OWN_VERSION: own_version_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_func_reg  <= s_func;
            req_hprog_reg <= s_header_program;
            req_hver_reg  <= s_header_version;
            req_mprog_reg <= s_map_program;
            req_mver_reg  <= s_map_version;
            req_mprot_reg <= s_map_protocol;
            req_mport_reg <= s_map_port;
            req_trail_reg <= s_trailing_data;
        end
    end

    // Header checks and procedure decode.
    always_comb begin
        early_status = ST_OK;
        early_supp   = '0;
        need_scan    = 1'b0;
        priority if (req_hprog_reg != own_program_reg) begin
            early_status = ST_PROG_UNAVAIL;
        end else if (req_hver_reg != own_version_reg) begin
            early_status = ST_PROG_MISMATCH;
            early_supp   = own_version_reg;
        end else begin
            unique case (req_func_reg)
                PROC_NULL, PROC_UNSET, PROC_DUMP, PROC_CALLIT: begin
                    early_status = ST_OK;
                end
                PROC_SET, PROC_GETPORT: begin
                    early_status = req_trail_reg ? ST_GARBAGE_ARGS : ST_OK;
                    need_scan    = !req_trail_reg;
                end
                default: begin
                    early_status = ST_PROC_UNAVAIL;
                end
            endcase
        end
    end

    assign is_set = (req_func_reg == PROC_SET);

    assign sts.need_scan = need_scan;
    assign sts.scan_last = (scan_idx_reg == LAST_IDX);

    // Scan address counter and compare-stage valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.scan_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_issue && !sts.scan_last) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        cmp_idx_reg <= scan_idx_reg;
    end

    // Table memory: one write port, one registered read port.
    assign mem_we = cmd.res_load && need_scan && is_set && !dup_reg && free_found_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[free_idx_reg] <= '{prog:     req_mprog_reg,
                                   version:  req_mver_reg,
                                   protocol: req_mprot_reg,
                                   port:     req_mport_reg};
        end
        rd_data_reg <= mem[scan_idx_reg];
        occ_reg     <= valid_reg[scan_idx_reg];
    end

    // Occupancy bits; reset empties the table at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // An unoccupied entry reads as a free slot with port zero.
    assign ent_port  = occ_reg ? rd_data_reg.port : '0;
    assign ent_match = occ_reg && (rd_data_reg.prog == req_mprog_reg)
                       && (rd_data_reg.version == req_mver_reg)
                       && (rd_data_reg.protocol == req_mprot_reg);

    // Scan accumulators: duplicate port, first free slot, first match.
    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) begin
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_port_reg   <= '0;
        end else if (cmp_en_reg) begin
            if (ent_port == req_mport_reg) begin
                dup_reg <= 1'b1;
            end
            if ((ent_port == '0) && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
            if (ent_match && !hit_reg) begin
                hit_reg      <= 1'b1;
                hit_port_reg <= ent_port;
            end
        end
    end

    // Outcome of a table scan.
    always_comb begin
        scan_status = ST_OK;
        scan_port   = '0;
        if (is_set) begin
            scan_status = (dup_reg || !free_found_reg) ? ST_SET_REFUSED : ST_OK;
        end else if (hit_reg) begin
            scan_port = hit_port_reg;
        end else begin
            scan_status = ST_GARBAGE_ARGS;
        end
    end

    // Result and output registers.
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= need_scan ? scan_status : early_status;
            res_port_reg   <= need_scan ? scan_port : '0;
            res_supp_reg   <= early_supp;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_port_reg   <= res_port_reg;
            out_supp_reg   <= res_supp_reg;
        end
    end

    assign m_status            = out_status_reg;
    assign m_found_port        = out_port_reg;
    assign m_supported_version = out_supp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rpmt_ctrl.sv
// ----------------------------------------------------------------------------
// Port mapping table controller
// Sequences decode, table scan, commit and reply, and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmt_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire                   m_ready,
    input  rpmt_pkg::dp_status_t  sts,
    output rpmt_pkg::ctrl_cmd_t   cmd
);

    import rpmt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_SCAN    = 6'b000100,
        S_TAIL    = 6'b001000,
        S_RESOLVE = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.need_scan) begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end else begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE: begin
                cmd.res_load = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register is full until the receiver takes the reply.
    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rpc_port_mapping_table_core.sv
// ----------------------------------------------------------------------------
// Portmapper mapping table core
// Takes one decoded portmapper request on the s_ channel and returns one
// reply on the m_ channel. Configuration writes set the own program and
// version numbers and take effect at once.
// Requests that fail the header checks, stubs and unknown procedures reply
// without a table scan. SET and GETPORT without trailing data scan the
// table, one entry per cycle through the table memory read port, and
// reply once the last entry has been compared. One request is in work at
// a time; the next is taken as soon as the previous reply sits in the
// output register.
// Reset restores the configuration defaults and empties the table at once
// through per-entry occupancy bits; no clearing pass is needed.
// When the receiver stalls, the reply holds in the output register; one more
// request is taken and worked, and it waits to load its reply until the
// pending one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpc_port_mapping_table_core_assert.svh"

module rpc_port_mapping_table_core #(
    parameter int TABLE_ENTRIES = rpmt_pkg::DEF_TABLE_ENTRIES
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [rpmt_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wire  [rpmt_pkg::WORD_W-1:0]          cfg_wr_data,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_func,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_header_program,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_header_version,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_map_program,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_map_version,
    input  wire  [rpmt_pkg::WORD_W-1:0]          s_map_protocol,
    input  wire  [rpmt_pkg::PORT_W-1:0]          s_map_port,
    input  wire                                  s_trailing_data,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [rpmt_pkg::STATUS_W-1:0]        m_status,
    output logic [rpmt_pkg::PORT_W-1:0]          m_found_port,
    output logic [rpmt_pkg::WORD_W-1:0]          m_supported_version
);

    import rpmt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // Request sequencer.
    rpmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table, checks and reply registers.
    rpmt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_func              (s_func),
        .s_header_program    (s_header_program),
        .s_header_version    (s_header_version),
        .s_map_program       (s_map_program),
        .s_map_version       (s_map_version),
        .s_map_protocol      (s_map_protocol),
        .s_map_port          (s_map_port),
        .s_trailing_data     (s_trailing_data),
        .cmd                 (cmd),
        .sts                 (sts),
        .m_status            (m_status),
        .m_found_port        (m_found_port),
        .m_supported_version (m_supported_version)
    );

    // An accepted request makes the block busy in the next cycle.
    `RPMT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A new reply never overwrites one the receiver has not taken.
    `RPMT_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_valid || m_ready)
    // Replies carry a defined status code.
    `RPMT_ASSERT_SAME(a_status_code, aclk, aresetn, m_valid, m_status <= ST_SET_REFUSED)
    // A found port only comes with an ok status.
    `RPMT_ASSERT_SAME(a_port_ok, aclk, aresetn, m_valid && (m_found_port != '0),
                      m_status == ST_OK)

endmodule

`default_nettype wire
